### rtl/frame_blend_weight_sequencer_top_defines.svh
// assertion macros for the frame blend weight sequencer
// used by frame_blend_weight_sequencer_top; expects clk and rst_n in scope
`ifndef FRAME_BLEND_WEIGHT_SEQUENCER_TOP_DEFINES_SVH
`define FRAME_BLEND_WEIGHT_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBW_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fbw assertion failed");

// next-cycle implication, checked out of reset
`define FBW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fbw assertion failed");

`endif

### rtl/fbw_pkg.sv
// shared types and constants for the frame blend weight sequencer
// no dependencies
`default_nettype none

package fbw_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int CNT_W       = 16;
  localparam int PERIOD_W    = 16;
  localparam int POS_W       = 2 * CNT_W;
  localparam int SUM_W       = 18;
  localparam int OUT_W       = WEIGHT_BITS + 1;
  localparam int MAX_RUN     = 64;
  localparam int RUN_W       = $clog2(MAX_RUN);
  localparam int DIV_W       = $clog2(WEIGHT_BITS);
  localparam int CFG_IDX_W   = 4;

  localparam logic [OUT_W-1:0] W_WHOLE = OUT_W'(1) << WEIGHT_BITS;
  localparam logic [SUM_W-1:0] W_LIMIT = SUM_W'((1 << WEIGHT_BITS) - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_PERIOD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_LOOP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_LOOP   = 4'd3;

  // overlap classes
  localparam logic [1:0] WC_ZERO  = 2'd0;
  localparam logic [1:0] WC_WHOLE = 2'd1;
  localparam logic [1:0] WC_DIV   = 2'd2;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  typedef struct packed {
    logic accept;    // input beat taken
    logic mul;       // wrap counters and form start positions
    logic add;       // form end positions
    logic cmp;       // classify overlap, load divider
    logic div_step;  // one quotient bit
    logic finish;    // update state and load result beat
    logic last;      // result beat closes the run
  } fbw_cmd_t;

  typedef struct packed {
    logic emit;      // source end at or after destination end
  } fbw_sts_t;

endpackage

`default_nettype wire

### rtl/frame_blend_weight_sequencer_top.sv
// sequence: each input beat starts a run; each result of the run goes through
// mul, add, classify, restoring divider and state update, then waits for output
// ready before the next result of the run starts
// throughput: one input beat per run, taken the cycle after its last result beat
// reset: synchronous, active low; counters and weight sum clear, periods and
// loops go to 1, no result beat pending
`default_nettype none

module frame_blend_weight_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbw_pkg::PERIOD_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fbw_pkg::OUT_W-1:0]          out_weight,
  output logic                               out_emit_frame,
  output logic                               out_last
);
  import fbw_pkg::*;

`include "frame_blend_weight_sequencer_top_defines.svh"

  fbw_cmd_t cmd;
  fbw_sts_t sts;

  // step sequencer
  fbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  fbw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .sts            (sts),
    .out_weight     (out_weight),
    .out_emit_frame (out_emit_frame),
    .out_last       (out_last)
  );

  // checks
  `FBW_ASSERT_NOW(a_busy_while_result, out_valid, !in_ready)
  `FBW_ASSERT_NOW(a_weight_range, out_valid, out_weight <= W_WHOLE)
  `FBW_ASSERT_NOW(a_no_emit_ends_run, out_valid && !out_emit_frame, out_last)
  `FBW_ASSERT_NEXT(a_accept_starts_step, in_valid && in_ready, !in_ready && !out_valid)

endmodule

`default_nettype wire

### rtl/fbw_ctrl.sv
// step sequencer for the frame blend weight sequencer
// depends on fbw_pkg
`default_nettype none

module fbw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire fbw_pkg::fbw_sts_t sts,
  output fbw_pkg::fbw_cmd_t     cmd
);
  import fbw_pkg::*;

  logic [2:0]       state_r, state_nxt;
  logic [RUN_W-1:0] run_cnt_r, run_cnt_nxt;
  logic [DIV_W-1:0] div_cnt_r, div_cnt_nxt;
  logic             last_c;

  // run ends when the source frame is used up or the run is full
  assign last_c    = !sts.emit || (run_cnt_r == RUN_W'(MAX_RUN - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    run_cnt_nxt  = run_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.last     = last_c;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          run_cnt_nxt = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_W'(1);
        if (div_cnt_r == DIV_W'(WEIGHT_BITS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_c) begin
            state_nxt = S_IDLE;
          end else begin
            run_cnt_nxt = run_cnt_r + RUN_W'(1);
            state_nxt   = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      run_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      run_cnt_r <= run_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/fbw_dp.sv
// datapath: config registers, counters, position math, overlap divider
// depends on fbw_pkg
`default_nettype none

module fbw_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbw_pkg::PERIOD_W-1:0]  cfg_data,
  input  wire logic                          in_restart,
  input  wire fbw_pkg::fbw_cmd_t             cmd,
  output fbw_pkg::fbw_sts_t                  sts,
  output logic [fbw_pkg::OUT_W-1:0]          out_weight,
  output logic                               out_emit_frame,
  output logic                               out_last
);
  import fbw_pkg::*;

  logic [PERIOD_W-1:0] src_period_r, dst_period_r;
  logic [CNT_W-1:0]    src_loop_r, dst_loop_r;
  logic [CNT_W-1:0]    src_cnt_r, dst_cnt_r;
  logic [SUM_W-1:0]    wsum_r;
  logic [POS_W-1:0]    ss_r, ds_r;
  logic [POS_W:0]      se_r, de_r;
  logic                emit_r;
  logic [1:0]          wcase_r;
  logic [WEIGHT_BITS-1:0] rem_r, quo_r;
  logic [OUT_W-1:0]    out_weight_r;
  logic                out_emit_r, out_last_r;

  logic [PERIOD_W-1:0] sp, dp;
  logic                wrap;
  logic [CNT_W-1:0]    sc_w, dc_w;
  logic [POS_W:0]      ss_x, ds_x;
  logic                gt_start, lt_end, se_ge_ds, ss_le_de;
  logic [POS_W:0]      diff_a, diff_b;
  logic [1:0]          wcase_nxt;
  logic [WEIGHT_BITS-1:0] numer_nxt;
  logic [WEIGHT_BITS:0] rem_sh;
  logic                q_bit;
  logic [OUT_W-1:0]    w_raw, given;
  logic [SUM_W-1:0]    wsum_nxt;

  // a zero period acts as one
  assign sp = (src_period_r == '0) ? PERIOD_W'(1) : src_period_r;
  assign dp = (dst_period_r == '0) ? PERIOD_W'(1) : dst_period_r;

  // loop wrap
  assign wrap = (src_cnt_r == src_loop_r) && (dst_cnt_r == dst_loop_r);
  assign sc_w = wrap ? '0 : src_cnt_r;
  assign dc_w = wrap ? '0 : dst_cnt_r;

  // overlap classification
  assign ss_x     = {1'b0, ss_r};
  assign ds_x     = {1'b0, ds_r};
  assign gt_start = (ss_x > ds_x);
  assign lt_end   = (se_r < de_r);
  assign se_ge_ds = (se_r >= ds_x);
  assign ss_le_de = (ss_x <= de_r);
  assign diff_a   = se_r - ds_x;
  assign diff_b   = de_r - ss_x;

  always_comb begin
    wcase_nxt = WC_ZERO;
    numer_nxt = '0;
    if (gt_start && lt_end) begin
      wcase_nxt = WC_DIV;
      numer_nxt = sp;
    end else if (!gt_start && lt_end && se_ge_ds) begin
      wcase_nxt = WC_DIV;
      numer_nxt = diff_a[WEIGHT_BITS-1:0];
    end else if (gt_start && !lt_end && ss_le_de) begin
      wcase_nxt = WC_DIV;
      numer_nxt = diff_b[WEIGHT_BITS-1:0];
    end else if (!gt_start && !lt_end) begin
      wcase_nxt = WC_WHOLE;
    end
  end

  // restoring divider step, remainder stays below the period
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, dp});

  // weight, gating by the running sum
  always_comb begin
    case (wcase_r)
      WC_WHOLE: w_raw = W_WHOLE;
      WC_DIV:   w_raw = {1'b0, quo_r};
      default:  w_raw = '0;
    endcase
  end

  assign given = ((w_raw != '0) && (wsum_r < W_LIMIT)) ? w_raw : '0;

  always_comb begin
    if (emit_r) begin
      wsum_nxt = '0;
    end else begin
      wsum_nxt = wsum_r + SUM_W'(given);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_period_r <= PERIOD_W'(1);
      dst_period_r <= PERIOD_W'(1);
      src_loop_r   <= CNT_W'(1);
      dst_loop_r   <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_PERIOD: src_period_r <= cfg_data;
        REG_DST_PERIOD: dst_period_r <= cfg_data;
        REG_SRC_LOOP:   src_loop_r   <= cfg_data;
        REG_DST_LOOP:   dst_loop_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      wsum_r    <= '0;
    end else if (cmd.accept && in_restart) begin
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      wsum_r    <= '0;
    end else if (cmd.mul) begin
      src_cnt_r <= sc_w;
      dst_cnt_r <= dc_w;
    end else if (cmd.finish) begin
      wsum_r <= wsum_nxt;
      if (emit_r) begin
        dst_cnt_r <= dst_cnt_r + CNT_W'(1);
      end else begin
        src_cnt_r <= src_cnt_r + CNT_W'(1);
      end
    end
  end

  // position pipeline, divider and result beat
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ss_r <= {{(POS_W-PERIOD_W){1'b0}}, sp} * {{(POS_W-CNT_W){1'b0}}, sc_w};
      ds_r <= {{(POS_W-PERIOD_W){1'b0}}, dp} * {{(POS_W-CNT_W){1'b0}}, dc_w};
    end
    if (cmd.add) begin
      se_r <= {1'b0, ss_r} + (POS_W+1)'(sp);
      de_r <= {1'b0, ds_r} + (POS_W+1)'(dp);
    end
    if (cmd.cmp) begin
      emit_r  <= !lt_end;
      wcase_r <= wcase_nxt;
      rem_r   <= numer_nxt;
      quo_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? WEIGHT_BITS'(rem_sh - {1'b0, dp}) : rem_sh[WEIGHT_BITS-1:0];
      quo_r <= {quo_r[WEIGHT_BITS-2:0], q_bit};
    end
    if (cmd.finish) begin
      out_weight_r <= given;
      out_emit_r   <= emit_r;
      out_last_r   <= cmd.last;
    end
  end

  assign sts.emit       = emit_r;
  assign out_weight     = out_weight_r;
  assign out_emit_frame = out_emit_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for frame_blend_weight_sequencer_top
// holds the blend-weight scoreboard class and the drivers; depends on fbw_pkg
module tb;
  import fbw_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int RANDOM_SETS   = 20;
  localparam int FRAMES_PER_SET = 20;
  localparam int REPORT_CAP    = 40;

  typedef struct packed {
    bit [OUT_W-1:0] weight;
    bit             emit_frame;
    bit             last;
  } blend_step_t;

  // tracks register and counter state, predicts the weight beats of each run
  class blend_scoreboard;
    bit [PERIOD_W-1:0] src_period, dst_period, src_loop, dst_loop;
    bit [CNT_W-1:0]    src_count, dst_count;
    bit [SUM_W-1:0]    weight_sum;
    blend_step_t       blend_steps[$];
    int                errors;

    function new();
      src_period = 1;
      dst_period = 1;
      src_loop   = 1;
      dst_loop   = 1;
      src_count  = 0;
      dst_count  = 0;
      weight_sum = 0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
      case (idx)
        REG_SRC_PERIOD: src_period = val;
        REG_DST_PERIOD: dst_period = val;
        REG_SRC_LOOP:   src_loop   = val;
        REG_DST_LOOP:   dst_loop   = val;
        default: ;
      endcase
    endfunction

    // share of destination span [d0,d1) covered by source span [s0,s1)
    function bit [63:0] frame_overlap(input bit [63:0] s0, s1, d0, d1);
      bit [63:0] whole, span;
      whole = 64'(W_WHOLE);
      span  = d1 - d0;
      if (span == 0) return whole;
      if (s0 > d0 && s1 < d1) return whole * (s1 - s0) / span;
      if (s0 <= d0 && s1 < d1 && s1 >= d0) return whole * (s1 - d0) / span;
      if (s0 > d0 && s1 >= d1 && s0 <= d1) return whole * (d1 - s0) / span;
      if (s0 <= d0 && s1 >= d1) return whole;
      return 0;
    endfunction

    // one accepted source frame: queue every weight beat of its run
    function void note_frame(input bit restart);
      bit [63:0]      sp, dp, s0, s1, d0, d1, w;
      bit [OUT_W-1:0] given;
      bit             emit, done;
      int             n;
      blend_step_t    step;
      sp = (src_period == 0) ? 64'd1 : 64'(src_period);
      dp = (dst_period == 0) ? 64'd1 : 64'(dst_period);
      if (restart) begin
        src_count  = 0;
        dst_count  = 0;
        weight_sum = 0;
      end
      n    = 0;
      done = 1'b0;
      while (!done) begin
        // both counters at their loop lengths: start the cycle over
        if (src_count == src_loop && dst_count == dst_loop) begin
          src_count = 0;
          dst_count = 0;
        end
        s0 = sp * src_count;
        s1 = s0 + sp;
        d0 = dp * dst_count;
        d1 = d0 + dp;
        w  = frame_overlap(s0, s1, d0, d1);
        given = '0;
        if (w != 0 && weight_sum < W_LIMIT) begin
          given      = w[OUT_W-1:0];
          weight_sum = weight_sum + w[SUM_W-1:0];
        end
        emit = (s1 >= d1);
        if (emit) begin
          weight_sum = 0;
          dst_count  = dst_count + 1'b1;
        end else begin
          src_count = src_count + 1'b1;
          done      = 1'b1;
        end
        n++;
        // long run is cut, counters left where they are
        if (n == MAX_RUN) done = 1'b1;
        step.weight     = given;
        step.emit_frame = emit;
        step.last       = done;
        blend_steps.push_back(step);
      end
    endfunction

    task report_mismatch(input string msg);
      if (errors < REPORT_CAP) $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(input logic [OUT_W-1:0] weight, input logic emit_frame, input logic last);
      blend_step_t want;
      if (blend_steps.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending, weight=%0d", weight));
        return;
      end
      want = blend_steps.pop_front();
      if (weight !== want.weight)
        report_mismatch($sformatf("weight %0d, want %0d", weight, want.weight));
      if (emit_frame !== want.emit_frame)
        report_mismatch($sformatf("emit_frame %b, want %b", emit_frame, want.emit_frame));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [PERIOD_W-1:0]  cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [OUT_W-1:0]     out_weight;
  logic                 out_emit_frame;
  logic                 out_last;

  int send_idle = 0;
  int recv_idle = 0;

  blend_scoreboard sb;

  frame_blend_weight_sequencer_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_weight     (out_weight),
    .out_emit_frame (out_emit_frame),
    .out_last       (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #80000000;
    $display("tb: FAIL");
    $finish;
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_weight, out_emit_frame, out_last);
    out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  task automatic set_idle(input int s, input int r);
    send_idle <= s;
    recv_idle <= r;
  endtask

  // one source frame beat, with an optional gap before it
  task automatic send_frame(input bit restart);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(restart);
  endtask

  // drop valid, wait for all pending beats, then let the block settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.blend_steps.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stray write to an unused index, then all four registers
  task automatic program_regs(input bit [15:0] sp, input bit [15:0] dp,
                              input bit [15:0] sl, input bit [15:0] dl);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [PERIOD_W-1:0]  val [5];
    idx[0] = CFG_IDX_W'($urandom_range(15, 4));
    val[0] = PERIOD_W'($urandom);
    idx[1] = REG_SRC_PERIOD;
    val[1] = sp;
    idx[2] = REG_DST_PERIOD;
    val[2] = dp;
    idx[3] = REG_SRC_LOOP;
    val[3] = sl;
    idx[4] = REG_DST_LOOP;
    val[4] = dl;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit [15:0] sp, dp, sl, dl;
    int        a, b, t, pick;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(11, 81);

    // reset register values, loops of one
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b0);
    send_frame(1'b0);

    // 3:2 ratio with matching loops, partial overlaps and wrap
    wait_drained();
    program_regs(16'd3, 16'd2, 16'd2, 16'd3);
    send_frame(1'b1);
    repeat (5) send_frame(1'b0);

    // zero periods act as one
    wait_drained();
    program_regs(16'd0, 16'd0, 16'd1, 16'd1);
    send_frame(1'b1);
    send_frame(1'b0);

    // long run cut at the run limit, next frame carries on
    wait_drained();
    program_regs(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    send_frame(1'b1);
    send_frame(1'b0);

    // counters already past shrunken loops
    wait_drained();
    program_regs(16'd2, 16'd3, 16'd2, 16'd3);
    send_frame(1'b0);
    send_frame(1'b0);

    // widest periods
    wait_drained();
    program_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    send_frame(1'b1);
    send_frame(1'b0);
    wait_drained();
    program_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
    send_frame(1'b1);
    send_frame(1'b0);

    // mismatched loops pile up the weight sum past its limit
    wait_drained();
    program_regs(16'd1, 16'd2, 16'd1, 16'd0);
    send_frame(1'b1);
    repeat (3) send_frame(1'b0);

    // random register sets, mostly continuing streams
    for (int s = 0; s < RANDOM_SETS; s++) begin
      if (s == RANDOM_SETS / 3) set_idle(81, 11);
      else if (s == 2 * RANDOM_SETS / 3) set_idle(0, 0);
      wait_drained();
      pick = $urandom_range(99);
      if (pick < 50) begin
        sp = 16'($urandom_range(16, 1));
        dp = 16'($urandom_range(16, 1));
      end else if (pick < 80) begin
        sp = 16'($urandom_range(1000, 1));
        dp = 16'($urandom_range(1000, 1));
      end else if (pick < 95) begin
        sp = 16'($urandom);
        dp = 16'($urandom);
      end else begin
        sp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        dp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        // loop lengths from the ratio of the effective periods
        a = (sp == 0) ? 1 : int'(sp);
        b = (dp == 0) ? 1 : int'(dp);
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        sl = 16'(((dp == 0) ? 1 : int'(dp)) / a);
        dl = 16'(((sp == 0) ? 1 : int'(sp)) / a);
      end else if (pick < 85) begin
        sl = 16'($urandom_range(8, 1));
        dl = 16'($urandom_range(8, 1));
      end else begin
        sl = 16'($urandom);
        dl = 16'($urandom);
      end
      program_regs(sp, dp, sl, dl);
      send_frame(1'b1);
      for (int k = 1; k < FRAMES_PER_SET; k++)
        send_frame($urandom_range(9) == 0);
    end

    // drain and close
    wait_drained();
    if (sb.blend_steps.size() != 0)
      sb.report_mismatch($sformatf("%0d result beats never arrived", sb.blend_steps.size()));
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### frame_blend_weight_sequencer_top.f
+incdir+rtl
rtl/fbw_pkg.sv
rtl/fbw_ctrl.sv
rtl/fbw_dp.sv
rtl/frame_blend_weight_sequencer_top.sv
tb/tb.sv
